// ===== src/sbmq_pkg.sv =====
// Shared types and codes for the shared-buffer multi-queue block.
// Used by the top level; no dependencies.
package sbmq_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_QRD,
        S_EXEC
    } t_state;

    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

endpackage

// ===== src/shared_buffer_multi_queue.sv =====
// Top level of the shared-buffer multi-queue: several FIFO queues linked through
// one entry pool with a free list. Depends on sbmq_pkg and sbmq_ram.
//
// Each input word carries an operation (enqueue or dequeue), a queue number and,
// for enqueue, a data word; each produces exactly one result word with a status
// (ok, overflow, underflow) and the dequeued data (zero unless a dequeue succeeds).
// State lives in three RAMs with registered reads: a per-queue head/tail
// table, a per-entry link table and the data store. Per-queue non-empty flags, the
// free-list head and a fill count sit in flip-flops. An enqueue goes from the
// accepting state straight to the execute state: queue table and free-list link
// are read at acceptance, and the writes and the result register land at the end
// of the execute state. A dequeue passes through a queue-read state in between,
// since the link of the head entry can only be addressed once the head has come
// back from the queue table. One item is in flight at a time and tready is low
// during reset. The result register lets a new word be accepted while the last
// result waits; a stalled output holds the item in its execute state. No clearing
// pass is needed after reset: link entries never allocated are recognized by a
// fill count and read as "next entry", which is the reset chain of the free list.
module shared_buffer_multi_queue
    import sbmq_pkg::*;
#(
    parameter int NUM_ENTRIES = 16,
    parameter int NUM_QUEUES  = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] data_in
    input  logic [2:0]  s_axis_tuser,   // [0] func, [2:1] queue_id
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] data_out
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    // IW holds an entry index or the end marker NUM_ENTRIES
    localparam int IW  = $clog2(NUM_ENTRIES + 1);
    localparam int EAW = $clog2(NUM_ENTRIES);
    localparam int QW  = NUM_QUEUES > 1 ? $clog2(NUM_QUEUES) : 1;
    localparam logic [IW-1:0] NIL = IW'(NUM_ENTRIES);

    t_state r_state, n_state;

    logic            r_func, n_func;
    logic [1:0]      r_q, n_q;
    logic [31:0]     r_data, n_data;

    logic [NUM_QUEUES-1:0] r_qne, n_qne;   // queue non-empty flags
    logic [IW-1:0]         r_free_head, n_free_head;
    logic [IW-1:0]         r_fill, n_fill; // entries below this were allocated at least once

    logic            r_out_valid, n_out_valid;
    logic [1:0]      r_out_status, n_out_status;
    logic [31:0]     r_out_data, n_out_data;

    // queue table: {head, tail}
    logic            qm_we;
    logic [QW-1:0]   qm_raddr;
    logic [2*IW-1:0] qm_wdata, qm_rdata;
    logic [IW-1:0]   qhead, qtail;

    logic            lk_we;
    logic [EAW-1:0]  lk_waddr, lk_raddr;
    logic [IW-1:0]   lk_wdata, lk_rdata;

    logic            wd_we;
    logic [31:0]     wd_rdata;

    logic [QW+1:0]   q_ext, in_q_ext;
    logic [QW-1:0]   q_addr, in_q_addr;
    logic            q_ok, q_ne;
    logic            free_nil, pristine, out_free;
    logic [IW-1:0]   nxt_free;

    assign q_ext     = {{QW{1'b0}}, r_q};
    assign in_q_ext  = {{QW{1'b0}}, s_axis_tuser[2:1]};
    assign q_addr    = q_ext[QW-1:0];
    assign in_q_addr = in_q_ext[QW-1:0];
    assign q_ok      = q_ext < (QW + 2)'(NUM_QUEUES);
    assign q_ne      = q_ok && r_qne[q_addr];

    assign qhead = qm_rdata[2*IW-1:IW];
    assign qtail = qm_rdata[IW-1:0];

    assign free_nil = r_free_head == NIL;
    // an entry never allocated still has its reset link: the next index
    assign pristine = r_free_head >= r_fill;
    assign nxt_free = pristine ? r_free_head + IW'(1) : lk_rdata;
    assign out_free = !r_out_valid || m_axis_tready;

    assign qm_raddr = (r_state == S_IDLE) ? in_q_addr : q_addr;
    assign lk_raddr = (r_state != S_IDLE && r_func == FUNC_DEQ) ? qhead[EAW-1:0]
                                                                : r_free_head[EAW-1:0];

    sbmq_ram #(.DEPTH(NUM_QUEUES), .WIDTH(2 * IW)) u_qtab (
        .i_clk   (i_clk),
        .i_we    (qm_we),
        .i_waddr (q_addr),
        .i_wdata (qm_wdata),
        .i_raddr (qm_raddr),
        .o_rdata (qm_rdata)
    );

    sbmq_ram #(.DEPTH(NUM_ENTRIES), .WIDTH(IW)) u_link (
        .i_clk   (i_clk),
        .i_we    (lk_we),
        .i_waddr (lk_waddr),
        .i_wdata (lk_wdata),
        .i_raddr (lk_raddr),
        .o_rdata (lk_rdata)
    );

    sbmq_ram #(.DEPTH(NUM_ENTRIES), .WIDTH(32)) u_word (
        .i_clk   (i_clk),
        .i_we    (wd_we),
        .i_waddr (r_free_head[EAW-1:0]),
        .i_wdata (r_data),
        .i_raddr (qhead[EAW-1:0]),
        .o_rdata (wd_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_func       = r_func;
        n_q          = r_q;
        n_data       = r_data;
        n_qne        = r_qne;
        n_free_head  = r_free_head;
        n_fill       = r_fill;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;
        qm_we        = 1'b0;
        qm_wdata     = qm_rdata;
        lk_we        = 1'b0;
        lk_waddr     = qtail[EAW-1:0];
        lk_wdata     = r_free_head;
        wd_we        = 1'b0;

        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_func  = s_axis_tuser[0];
                    n_q     = s_axis_tuser[2:1];
                    n_data  = s_axis_tdata;
                    n_state = (s_axis_tuser[0] == FUNC_DEQ) ? S_QRD : S_EXEC;
                end
            end
            S_QRD: begin
                // head is back; link and word of the head are read this cycle
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_out_data  = '0;
                    if (r_func == FUNC_ENQ) begin
                        if (!q_ok || free_nil) begin
                            n_out_status = ST_OVERFLOW;
                        end else begin
                            n_out_status = ST_OK;
                            n_free_head  = nxt_free;
                            if (pristine) begin
                                n_fill = r_fill + IW'(1);
                            end
                            wd_we = 1'b1;
                            qm_we = 1'b1;
                            if (q_ne) begin
                                // append behind the tail; tail's own link is never read
                                lk_we    = 1'b1;
                                lk_waddr = qtail[EAW-1:0];
                                lk_wdata = r_free_head;
                                qm_wdata = {qhead, r_free_head};
                            end else begin
                                qm_wdata       = {r_free_head, r_free_head};
                                n_qne[q_addr]  = 1'b1;
                            end
                        end
                    end else begin
                        if (!q_ne) begin
                            n_out_status = ST_UNDERFLOW;
                        end else begin
                            n_out_status = ST_OK;
                            n_out_data   = wd_rdata;
                            // push the old head onto the free list
                            lk_we        = 1'b1;
                            lk_waddr     = qhead[EAW-1:0];
                            lk_wdata     = r_free_head;
                            n_free_head  = qhead;
                            if (qhead == qtail) begin
                                n_qne[q_addr] = 1'b0;
                            end else begin
                                qm_we    = 1'b1;
                                qm_wdata = {lk_rdata, qtail};
                            end
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_qne       <= '0;
            r_free_head <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_qne       <= n_qne;
            r_free_head <= n_free_head;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func       <= n_func;
        r_q          <= n_q;
        r_data       <= n_data;
        r_out_status <= n_out_status;
        r_out_data   <= n_out_data;
    end

    assign s_axis_tready = (r_state == S_IDLE) && i_rst_n;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

endmodule

// ===== src/sbmq_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one read port, registered read.
// No dependencies.
module sbmq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                    i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                    o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== verif/tb_shared_buffer_multi_queue.sv =====
// Self-checking testbench for shared_buffer_multi_queue: drives enqueue/dequeue words,
// predicts every result from a linked-list model of its own and checks each result word.
// Depends on sbmq_pkg and the shared_buffer_multi_queue RTL.
module tb_shared_buffer_multi_queue
    import sbmq_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_ENTRIES = 16;
    localparam int NUM_QUEUES  = 4;
    localparam logic [4:0] NIL_ENTRY = 5'(NUM_ENTRIES);   // end-of-list / empty marker
    localparam int CLK_HALF    = 5;
    localparam int RST_CYCLES  = 12;
    localparam int PHASE_OPS   = 210;
    localparam int TAIL_CYCLES = 20;      // wait at the end for a stray result word
    localparam int CYCLE_LIMIT = 200000;  // guard against a hung run
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic        op;
        logic [1:0]  qid;
        logic [31:0] word;
    } t_list_op;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] word;
    } t_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;      // [31:0] data_in
    logic [2:0]  s_axis_tuser = '0;      // [0] func, [2:1] queue_id
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [31:0] data_out
    logic [1:0]  m_axis_tuser;           // [1:0] status

    shared_buffer_multi_queue #(
        .NUM_ENTRIES(NUM_ENTRIES),
        .NUM_QUEUES (NUM_QUEUES)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: its own copy of the queue heads/tails, the link
    // array, the word store and the free-list head.
    // ------------------------------------------------------------------
    logic [4:0]  head_tbl [NUM_QUEUES];
    logic [4:0]  tail_tbl [NUM_QUEUES];
    logic [4:0]  link_tbl [NUM_ENTRIES];
    logic [31:0] word_tbl [NUM_ENTRIES];
    logic [4:0]  free_head;

    t_list_op op_backlog[$];     // words waiting to be driven
    t_reply   due_replies[$];    // predicted results, oldest first

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit in_fire = 1'b0;          // input word taken at the last rising edge
    int cycle_cnt = 0;
    int errors = 0;
    int n_enq_ok = 0, n_overflow = 0, n_deq_ok = 0, n_underflow = 0;
    int n_checked = 0;
    int fill_now = 0, fill_peak = 0;

    // One enqueue or dequeue applied to the predictor's lists.
    task automatic run_list_op(input logic op, input logic [1:0] qid, input logic [31:0] word,
                               output logic [1:0] st, output logic [31:0] dout);
        logic [4:0] slot;
        logic [4:0] nxt;
        st   = ST_OK;
        dout = '0;
        if (op == FUNC_ENQ) begin
            slot = free_head;
            if (qid >= NUM_QUEUES || slot == NIL_ENTRY) begin
                st = ST_OVERFLOW;        // pool exhausted: nothing changes
            end else begin
                free_head = link_tbl[slot];
                if (head_tbl[qid] == NIL_ENTRY) begin
                    head_tbl[qid] = slot;
                end else if (tail_tbl[qid] != NIL_ENTRY) begin
                    link_tbl[tail_tbl[qid]] = slot;
                end
                link_tbl[slot] = NIL_ENTRY;
                tail_tbl[qid]  = slot;
                word_tbl[slot] = word;
            end
        end else begin
            if (qid >= NUM_QUEUES || head_tbl[qid] == NIL_ENTRY) begin
                st = ST_UNDERFLOW;       // empty queue: nothing changes
            end else begin
                slot = head_tbl[qid];
                nxt  = link_tbl[slot];
                head_tbl[qid] = nxt;
                if (nxt == NIL_ENTRY) begin
                    tail_tbl[qid] = NIL_ENTRY;   // queue drained
                end
                link_tbl[slot] = free_head;
                free_head = slot;
                dout = word_tbl[slot];
            end
        end
    endtask

    task automatic report_bad(input string msg);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("ERROR @%0d: %s", cycle_cnt, msg);
        end
    endtask

    task automatic queue_op(input logic op, input logic [1:0] qid, input logic [31:0] word);
        t_list_op item;
        item.op   = op;
        item.qid  = qid;
        item.word = word;
        op_backlog.push_back(item);
    endtask

    // Random traffic for one phase. It opens with a run of enqueues long
    // enough to exhaust the pool, then runs filling, mixed and
    // draining bursts at random so both overflow and underflow come up repeatedly.
    // Some bursts stay on one queue to build long chains.
    task automatic fill_phase(input int n_ops);
        int made;
        int len;
        int enq_pct;
        int focus_q;
        logic op;
        logic [1:0] qid;
        made = 0;
        repeat (NUM_ENTRIES + 2) begin
            queue_op(FUNC_ENQ, 2'($urandom_range(NUM_QUEUES - 1)), $urandom);
            made++;
        end
        while (made < n_ops) begin
            case ($urandom_range(2))
                0: enq_pct = 85;
                1: enq_pct = 50;
                default: enq_pct = 15;
            endcase
            focus_q = $urandom_range(NUM_QUEUES);   // NUM_QUEUES means "any queue"
            len = $urandom_range(10, 40);
            if (len > n_ops - made) len = n_ops - made;
            repeat (len) begin
                op  = ($urandom_range(99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
                qid = (focus_q == NUM_QUEUES) ? 2'($urandom_range(NUM_QUEUES - 1))
                                              : 2'(focus_q);
                queue_op(op, qid, $urandom);
                made++;
            end
        end
    endtask

    // Hold off until everything sent has been answered. The check runs
    // after the driver's falling-edge updates have settled.
    task automatic wait_drained();
        while (op_backlog.size() != 0 || s_axis_tvalid || due_replies.size() != 0) begin
            @(negedge i_clk);
            #1;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: updates inputs at the falling edge. A word stays on the bus
    // until it is taken; the sender and receiver idle at the phase rates.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_ops
        t_list_op nxt;
        if (i_rst_n) begin
            if (!s_axis_tvalid || in_fire) begin
                if (op_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = op_backlog.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.word;
                    s_axis_tuser  <= {nxt.qid, nxt.op};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: samples both sides at the rising edge. An accepted input
    // word is run through the predictor; an accepted result word is
    // compared with the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_ports
        logic [1:0]  st;
        logic [31:0] dout;
        t_reply      want;
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, due_replies.size());
            $display("tb_shared_buffer_multi_queue: done, errors");
            $finish;
        end else begin
            in_fire = 1'b0;
            if (i_rst_n) begin
                if (s_axis_tvalid && s_axis_tready) begin
                    in_fire = 1'b1;
                    run_list_op(s_axis_tuser[0], s_axis_tuser[2:1], s_axis_tdata, st, dout);
                    case (st)
                        ST_OVERFLOW:  n_overflow++;
                        ST_UNDERFLOW: n_underflow++;
                        default: begin
                            if (s_axis_tuser[0] == FUNC_ENQ) begin
                                n_enq_ok++;
                                fill_now++;
                            end else begin
                                n_deq_ok++;
                                fill_now--;
                            end
                        end
                    endcase
                    if (fill_now > fill_peak) fill_peak = fill_now;
                    due_replies.push_back('{status: st, word: dout});
                end
                if (m_axis_tvalid && m_axis_tready) begin
                    if (due_replies.size() == 0) begin
                        report_bad($sformatf("unexpected result status=%0d data=%h",
                                             m_axis_tuser, m_axis_tdata));
                    end else begin
                        want = due_replies.pop_front();
                        n_checked++;
                        if (m_axis_tuser !== want.status) begin
                            report_bad($sformatf("result %0d status: expected %0d, got %0d",
                                                 n_checked, want.status, m_axis_tuser));
                        end
                        if (m_axis_tdata !== want.word) begin
                            report_bad($sformatf("result %0d data: expected %h, got %h",
                                                 n_checked, want.word, m_axis_tdata));
                        end
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and sequencing
    // ------------------------------------------------------------------
    initial begin : run_test
        for (int q = 0; q < NUM_QUEUES; q++) begin
            head_tbl[q] = NIL_ENTRY;
            tail_tbl[q] = NIL_ENTRY;
        end
        for (int e = 0; e < NUM_ENTRIES; e++) begin
            link_tbl[e] = 5'(e + 1);     // reset chain of the free list
            word_tbl[e] = '0;
        end
        free_head = '0;

        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed words: dequeue from every empty queue, data extremes,
        // a queue drained back to empty, and reuse of a freed entry.
        for (int q = 0; q < NUM_QUEUES; q++) queue_op(FUNC_DEQ, 2'(q), 32'hFFFF_FFFF);
        queue_op(FUNC_ENQ, 2'd0, 32'h7FFF_FFFF);
        queue_op(FUNC_ENQ, 2'd0, 32'h8000_0000);
        queue_op(FUNC_ENQ, 2'd1, 32'h0000_0000);
        queue_op(FUNC_ENQ, 2'd2, 32'hFFFF_FFFF);
        queue_op(FUNC_ENQ, 2'd3, 32'h0000_0001);
        queue_op(FUNC_DEQ, 2'd0, 32'h0);
        queue_op(FUNC_DEQ, 2'd0, 32'h0);
        queue_op(FUNC_DEQ, 2'd0, 32'h0);         // just drained: underflow
        queue_op(FUNC_DEQ, 2'd3, 32'h0);
        queue_op(FUNC_ENQ, 2'd3, 32'hA5A5_A5A5); // takes the entry just freed
        queue_op(FUNC_DEQ, 2'd3, 32'h0);
        queue_op(FUNC_DEQ, 2'd1, 32'h0);
        queue_op(FUNC_DEQ, 2'd2, 32'h0);

        // Phase 1: sender idles 35%, receiver 49%.
        send_idle_pct = 35;
        recv_idle_pct = 49;
        fill_phase(PHASE_OPS);
        wait_drained();          // sender holds until every result is back

        // Phase 2: rates swapped.
        send_idle_pct = 49;
        recv_idle_pct = 35;
        fill_phase(PHASE_OPS);
        wait_drained();

        // Phase 3: back to back on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fill_phase(PHASE_OPS);
        wait_drained();

        // Let any stray result word show up before closing.
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("checked %0d results: %0d enq ok, %0d overflow, %0d deq ok, %0d underflow",
                 n_checked, n_enq_ok, n_overflow, n_deq_ok, n_underflow);
        $display("pool peak fill %0d of %0d entries, %0d cycles, %0d mismatches",
                 fill_peak, NUM_ENTRIES, cycle_cnt, errors);
        if (errors == 0 && due_replies.size() == 0) begin
            $display("tb_shared_buffer_multi_queue: done, clean");
        end else begin
            $display("tb_shared_buffer_multi_queue: done, errors");
        end
        $finish;
    end

endmodule
